/* rtl/spfq_pkg.sv */
// ----------------------------------------------------------------------------
// spfq_pkg
// Shared codes, character constants and the command type passed from the
// front part to the back part of the strict priority four queue unit.
// ----------------------------------------------------------------------------
package spfq_pkg;

    localparam int NUM_CLASSES = 4;

    localparam logic [1:0] REQ_ARRIVE = 2'd0;
    localparam logic [1:0] REQ_SERVE  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_REPORT = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CLASS = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] CLS_V = 2'd0;
    localparam logic [1:0] CLS_A = 2'd1;
    localparam logic [1:0] CLS_D = 2'd2;
    localparam logic [1:0] CLS_B = 2'd3;

    localparam logic [7:0] CHAR_V      = 8'h56;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_D      = 8'h44;
    localparam logic [7:0] CHAR_B      = 8'h42;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic signed [12:0] MINUTES_PER_HOUR = 13'sd60;
    localparam logic [15:0]        COUNT_MAX        = 16'hffff;
    localparam logic [6:0]         PEAK_MAX         = 7'd127;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] ticket;
        logic        cls_ok;
        logic [1:0]  cls;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_cmd;

endpackage

/* rtl/spfq_front.sv */
// ----------------------------------------------------------------------------
// spfq_front
// Accepts request items, folds the class character to a class code and holds
// the decoded commands in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module spfq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [15:0]        i_ticket,
    input  logic [7:0]         i_class_char,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic               i_pop,
    output logic               o_cmd_valid,
    output spfq_pkg::t_cmd     o_cmd
);
    import spfq_pkg::*;

    localparam int QD = 2;

    t_cmd       w_cmd;
    logic [7:0] w_char;
    logic       w_push;

    t_cmd       r_q [QD];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // upper-case and classify
    always_comb begin
        w_char = i_class_char;
        if (i_class_char >= CHAR_LOW_A && i_class_char <= CHAR_LOW_Z) begin
            w_char = i_class_char - CASE_OFFSET;
        end
        w_cmd.req    = i_req_type;
        w_cmd.ticket = i_ticket;
        w_cmd.hour   = i_hour;
        w_cmd.minute = i_minute;
        w_cmd.cls_ok = 1'b1;
        case (w_char)
            CHAR_V: begin
                w_cmd.cls = CLS_V;
            end
            CHAR_A: begin
                w_cmd.cls = CLS_A;
            end
            CHAR_D: begin
                w_cmd.cls = CLS_D;
            end
            CHAR_B: begin
                w_cmd.cls = CLS_B;
            end
            default: begin
                w_cmd.cls    = CLS_V;
                w_cmd.cls_ok = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_count == 2'(QD));
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

endmodule

/* rtl/spfq_back.sv */
// ----------------------------------------------------------------------------
// spfq_back
// Executes decoded commands: keeps the four class rings in one entry memory,
// the per-class pointers, lengths and totals, the statistics, and the result
// register that faces the output channel.
// ----------------------------------------------------------------------------
module spfq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  spfq_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [1:0]          o_served_class,
    output logic [15:0]         o_served_ticket,
    output logic signed [11:0]  o_wait_minutes,
    output logic [15:0]         o_value_red,
    output logic [15:0]         o_value_yellow,
    output logic [15:0]         o_value_green,
    output logic [15:0]         o_value_white,
    output logic [15:0]         o_total_served,
    output logic [6:0]          o_peak_occupancy,
    output logic [10:0]         o_max_wait
);
    import spfq_pkg::*;

    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int LW        = $clog2(QUEUE_DEPTH + 1);
    localparam int TW        = LW + 2;
    localparam int AW        = PW + 2;
    localparam int MEM_DEPTH = NUM_CLASSES * (1 << PW);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    t_state        r_state, n_state;
    logic [PW-1:0] r_head [NUM_CLASSES];
    logic [PW-1:0] n_head [NUM_CLASSES];
    logic [PW-1:0] r_tail [NUM_CLASSES];
    logic [PW-1:0] n_tail [NUM_CLASSES];
    logic [LW-1:0] r_len  [NUM_CLASSES];
    logic [LW-1:0] n_len  [NUM_CLASSES];
    logic [15:0]   r_tot  [NUM_CLASSES];
    logic [15:0]   n_tot  [NUM_CLASSES];
    logic [15:0]   r_served, n_served;
    logic [6:0]    r_peak, n_peak;
    logic [10:0]   r_maxw, n_maxw;
    logic [1:0]    r_cls, n_cls;
    logic [4:0]    r_svc_hour, n_svc_hour;
    logic [5:0]    r_svc_min, n_svc_min;

    logic [26:0]   r_mem [MEM_DEPTH];
    logic [26:0]   r_rd_data;
    logic          w_mem_we;
    logic          w_mem_re;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    logic               r_o_valid, n_o_valid;
    logic [1:0]         r_o_status, n_o_status;
    logic [1:0]         r_o_cls, n_o_cls;
    logic [15:0]        r_o_ticket, n_o_ticket;
    logic signed [11:0] r_o_wait, n_o_wait;
    logic [15:0]        r_o_val [NUM_CLASSES];
    logic [15:0]        n_o_val [NUM_CLASSES];
    logic [15:0]        r_o_total, n_o_total;
    logic [6:0]         r_o_peak, n_o_peak;
    logic [10:0]        r_o_maxw, n_o_maxw;

    logic               w_out_free;
    logic               w_load;
    logic               w_any;
    logic [1:0]         w_sel;
    logic [TW-1:0]      w_total;
    logic [15:0]        w_total16;
    logic [6:0]         w_peak_cand;
    logic signed [12:0] w_dh;
    logic signed [12:0] w_dm;
    logic signed [12:0] w_wait;

    assign w_out_free = !r_o_valid || !i_out_stall;

    // highest-priority (lowest-index) nonempty class
    always_comb begin
        w_any = 1'b0;
        w_sel = CLS_V;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (r_len[k] != '0) begin
                w_any = 1'b1;
                w_sel = 2'(k);
            end
        end
    end

    always_comb begin
        w_dh   = $signed({8'b0, r_svc_hour}) - $signed({8'b0, r_rd_data[10:6]});
        w_dm   = $signed({7'b0, r_svc_min}) - $signed({7'b0, r_rd_data[5:0]});
        w_wait = 13'(w_dh * MINUTES_PER_HOUR) + w_dm;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_tot      = r_tot;
        n_served   = r_served;
        n_peak     = r_peak;
        n_maxw     = r_maxw;
        n_cls      = r_cls;
        n_svc_hour = r_svc_hour;
        n_svc_min  = r_svc_min;
        o_pop      = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_wr_addr  = {i_cmd.cls, r_tail[i_cmd.cls]};
        w_rd_addr  = {w_sel, r_head[w_sel]};
        w_load     = 1'b0;
        w_total    = '0;
        w_total16  = '0;
        w_peak_cand = '0;
        n_o_status = r_o_status;
        n_o_cls    = r_o_cls;
        n_o_ticket = r_o_ticket;
        n_o_wait   = r_o_wait;
        n_o_val    = r_o_val;
        n_o_total  = r_o_total;
        n_o_peak   = r_o_peak;
        n_o_maxw   = r_o_maxw;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_pop      = 1'b1;
                    w_load     = 1'b1;
                    n_o_status = ST_OK;
                    n_o_cls    = CLS_V;
                    n_o_ticket = '0;
                    n_o_wait   = '0;
                    for (int k = 0; k < NUM_CLASSES; k++) begin
                        n_o_val[k] = '0;
                    end
                    case (i_cmd.req)
                        REQ_ARRIVE: begin
                            if (!i_cmd.cls_ok) begin
                                n_o_status = ST_BAD_CLASS;
                            end else if (r_len[i_cmd.cls] == LW'(QUEUE_DEPTH)) begin
                                n_o_status = ST_FULL;
                            end else begin
                                w_mem_we = 1'b1;
                                n_tail[i_cmd.cls] = adv(r_tail[i_cmd.cls]);
                                n_len[i_cmd.cls]  = r_len[i_cmd.cls] + LW'(1);
                                for (int k = 0; k < NUM_CLASSES; k++) begin
                                    w_total = w_total + TW'(n_len[k]);
                                end
                                w_total16   = 16'(w_total);
                                w_peak_cand = (w_total16 > 16'(PEAK_MAX)) ?
                                              PEAK_MAX : w_total16[6:0];
                                if (w_peak_cand > r_peak) begin
                                    n_peak = w_peak_cand;
                                end
                            end
                        end
                        REQ_SERVE: begin
                            if (!w_any) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                w_load        = 1'b0;
                                w_mem_re      = 1'b1;
                                n_head[w_sel] = adv(r_head[w_sel]);
                                n_len[w_sel]  = r_len[w_sel] - LW'(1);
                                n_tot[w_sel]  = sat_inc(r_tot[w_sel]);
                                n_served      = sat_inc(r_served);
                                n_cls         = w_sel;
                                n_svc_hour    = i_cmd.hour;
                                n_svc_min     = i_cmd.minute;
                                n_state       = S_CALC;
                            end
                        end
                        REQ_QUERY: begin
                            for (int k = 0; k < NUM_CLASSES; k++) begin
                                n_o_val[k] = 16'(r_len[k]);
                            end
                        end
                        REQ_REPORT: begin
                            n_o_val = r_tot;
                        end
                        default: begin
                            n_o_status = ST_OK;
                        end
                    endcase
                end
            end
            S_CALC: begin
                w_load     = 1'b1;
                n_o_status = ST_OK;
                n_o_cls    = r_cls;
                n_o_ticket = r_rd_data[26:11];
                n_o_wait   = w_wait[11:0];
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    n_o_val[k] = '0;
                end
                if (!w_wait[12] && w_wait != '0 && w_wait[10:0] > r_maxw) begin
                    n_maxw = w_wait[10:0];
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_o_total = n_served;
            n_o_peak  = n_peak;
            n_o_maxw  = n_maxw;
        end

        if (w_load) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_served  <= '0;
            r_peak    <= '0;
            r_maxw    <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_len[k]  <= '0;
                r_tot[k]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_served  <= n_served;
            r_peak    <= n_peak;
            r_maxw    <= n_maxw;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_len     <= n_len;
            r_tot     <= n_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls      <= n_cls;
        r_svc_hour <= n_svc_hour;
        r_svc_min  <= n_svc_min;
        r_o_status <= n_o_status;
        r_o_cls    <= n_o_cls;
        r_o_ticket <= n_o_ticket;
        r_o_wait   <= n_o_wait;
        r_o_val    <= n_o_val;
        r_o_total  <= n_o_total;
        r_o_peak   <= n_o_peak;
        r_o_maxw   <= n_o_maxw;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= {i_cmd.ticket, i_cmd.hour, i_cmd.minute};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_served_class   = r_o_cls;
    assign o_served_ticket  = r_o_ticket;
    assign o_wait_minutes   = r_o_wait;
    assign o_value_red      = r_o_val[0];
    assign o_value_yellow   = r_o_val[1];
    assign o_value_green    = r_o_val[2];
    assign o_value_white    = r_o_val[3];
    assign o_total_served   = r_o_total;
    assign o_peak_occupancy = r_o_peak;
    assign o_max_wait       = r_o_maxw;

endmodule

/* rtl/strict_priority_four_queue_stats_unit.sv */
// ----------------------------------------------------------------------------
// strict_priority_four_queue_stats_unit
// Four strict priority ticket queues (V, A, D, B) with wait and occupancy
// statistics; one result item for each request item.
//
//   channel  direction  handshake                  payload
//   in       into unit  i_in_valid / o_in_stall    req_type ticket class_char
//                                                  hour minute
//   out      from unit  o_out_valid / i_out_stall  status served_class ...
//                                                  max_wait
//
// Requests pass the command queue and the result register; successful serves
// also pass the registered entry memory read port. Rate is one item a cycle
// while i_out_stall is low; a successful serve holds the back part in S_CALC
// before its next pop. Reset is synchronous, active low, and leaves all queues
// empty and all statistics at zero. A two-entry command queue keeps accepting
// while the result register is held by i_out_stall, then stalls the input.
// ----------------------------------------------------------------------------
module strict_priority_four_queue_stats_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [15:0]        i_ticket,
    input  logic [7:0]         i_class_char,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [1:0]         o_served_class,
    output logic [15:0]        o_served_ticket,
    output logic signed [11:0] o_wait_minutes,
    output logic [15:0]        o_value_red,
    output logic [15:0]        o_value_yellow,
    output logic [15:0]        o_value_green,
    output logic [15:0]        o_value_white,
    output logic [15:0]        o_total_served,
    output logic [6:0]         o_peak_occupancy,
    output logic [10:0]        o_max_wait
);
    import spfq_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_pop;

    spfq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_ticket     (i_ticket),
        .i_class_char (i_class_char),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_pop        (w_pop),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd)
    );

    spfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_cmd_valid),
        .i_cmd            (w_cmd),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_served_class   (o_served_class),
        .o_served_ticket  (o_served_ticket),
        .o_wait_minutes   (o_wait_minutes),
        .o_value_red      (o_value_red),
        .o_value_yellow   (o_value_yellow),
        .o_value_green    (o_value_green),
        .o_value_white    (o_value_white),
        .o_total_served   (o_total_served),
        .o_peak_occupancy (o_peak_occupancy),
        .o_max_wait       (o_max_wait)
    );

endmodule
